@@ src/ps2mpt_pkg.sv @@
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker package
// Widths shared by the channel interfaces and the tracker, and the header test
// constants and cursor arithmetic used by the tracker.
// ----------------------------------------------------------------------------
package ps2mpt_pkg;

	// Payload widths.
	localparam int BYTE_W   = 8;
	localparam int BTN_W    = 3;
	localparam int DELTA_W  = 9;
	localparam int POS_W    = 12;
	localparam int SIZE_W   = 13;
	localparam int CFG_IDX_W = 1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

	// Register reset values.
	localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd640;
	localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd480;

	// Header test: bits 7 and 6 clear, bit 3 (always one) set.
	localparam logic [BYTE_W-1:0] HDR_MASK  = 8'hC8;
	localparam logic [BYTE_W-1:0] HDR_MATCH = 8'h08;

	// Header bit positions.
	localparam int HDR_XSIGN = 4;
	localparam int HDR_YSIGN = 5;

	// Largest usable screen size; the position is only POS_W bits wide.
	localparam logic [SIZE_W-1:0] POS_LIMIT = 13'd4096;

	// Bring a size register into the range 1 to POS_LIMIT.
	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] sz);
		logic [SIZE_W-1:0] r;
		if (sz == '0)
			r = 13'd1;
		else if (sz > POS_LIMIT)
			r = POS_LIMIT;
		else
			r = sz;
		return r;
	endfunction

	// Sign-extend a delta byte; a zero byte stays zero whatever its sign bit.
	function automatic logic signed [DELTA_W-1:0] sext_delta(input logic [BYTE_W-1:0] b,
			input logic neg);
		logic s;
		s = neg && (b != '0);
		return $signed({s, b});
	endfunction

	// Add a delta to a position and clamp the sum to 0 .. lim-1.
	function automatic logic [POS_W-1:0] move_clamp(input logic [POS_W-1:0] pos,
			input logic signed [DELTA_W-1:0] d, input logic [SIZE_W-1:0] lim);
		logic signed [POS_W+1:0] p;
		logic [SIZE_W-1:0] top;
		logic [POS_W-1:0] r;
		p   = $signed({2'b00, pos}) + $signed({{(POS_W+2-DELTA_W){d[DELTA_W-1]}}, d});
		top = lim - 13'd1;
		if (p[POS_W+1])
			r = '0;
		else if (p >= $signed({1'b0, lim}))
			r = top[POS_W-1:0];
		else
			r = p[POS_W-1:0];
		return r;
	endfunction

endpackage

@@ src/ps2mpt_if.sv @@
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker channels
// Valid/ready channels for received bytes and for decoded packet words.
// ----------------------------------------------------------------------------

// Byte channel from the PS/2 receiver.
interface ps2mpt_byte_if;
	logic                             valid;
	logic                             ready;
	logic [ps2mpt_pkg::BYTE_W-1:0]    rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

// Packet channel towards the consumer.
interface ps2mpt_pkt_if;
	logic                                  valid;
	logic                                  ready;
	logic [ps2mpt_pkg::BTN_W-1:0]          buttons;
	logic signed [ps2mpt_pkg::DELTA_W-1:0] delta_x;
	logic signed [ps2mpt_pkg::DELTA_W-1:0] delta_y;
	logic [ps2mpt_pkg::POS_W-1:0]          cursor_x;
	logic [ps2mpt_pkg::POS_W-1:0]          cursor_y;

	modport source (output valid, output buttons, output delta_x, output delta_y,
		output cursor_x, output cursor_y, input ready);
	modport sink   (input valid, input buttons, input delta_x, input delta_y,
		input cursor_x, input cursor_y, output ready);
endinterface

@@ src/ps2_mouse_packet_tracker_unit.sv @@
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker
// Decodes three-byte PS/2 mouse packets and tracks a clamped cursor position.
// ----------------------------------------------------------------------------
//
//  Channel    Dir   Word                                   Handshake
//  ---------  ----  -------------------------------------  ---------------
//  rx         in    rx_byte                                valid / ready
//  pkt        out   buttons, delta_x/y, cursor_x/y         valid / ready
//  cfg        in    cfg_index, cfg_wdata                   cfg_we only
//
// One byte is accepted per cycle unless the input register stalls. A byte is
// captured in the input register and decoded in the following cycle; a packet
// enters the result register as its Y byte leaves the input register. Only the
// input register stalls, and only when it holds a Y byte while an untaken
// packet word sits in the result register. Reset clears the phase, the stored
// header and X byte, the cursor and both registers' valid flags.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_tracker_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	ps2mpt_byte_if.sink                          rx,
	ps2mpt_pkt_if.source                         pkt,
	input  logic                                 cfg_we,
	input  logic [ps2mpt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ps2mpt_pkg::SIZE_W-1:0]        cfg_wdata
);

	typedef enum logic [1:0] {
		PH_ACK = 2'd0,
		PH_HDR = 2'd1,
		PH_X   = 2'd2,
		PH_Y   = 2'd3
	} phase_t;

	// Configuration registers.
	logic [ps2mpt_pkg::SIZE_W-1:0] width_q;
	logic [ps2mpt_pkg::SIZE_W-1:0] height_q;

	// Input register.
	logic                          valid_s1;
	logic [ps2mpt_pkg::BYTE_W-1:0] byte_s1;

	// Packet state.
	phase_t                        phase_q;
	logic [ps2mpt_pkg::BYTE_W-1:0] header_q;
	logic [ps2mpt_pkg::BYTE_W-1:0] xbyte_q;
	logic [ps2mpt_pkg::POS_W-1:0]  pos_x_q;
	logic [ps2mpt_pkg::POS_W-1:0]  pos_y_q;

	// Result register.
	logic                                  out_valid_q;
	logic [ps2mpt_pkg::BTN_W-1:0]          buttons_q;
	logic signed [ps2mpt_pkg::DELTA_W-1:0] delta_x_q;
	logic signed [ps2mpt_pkg::DELTA_W-1:0] delta_y_q;

	// Decode of the captured byte.
	logic                                  s1_done;
	logic                                  s1_fire;
	logic                                  s1_ends_pkt;
	logic                                  hdr_ok;
	logic signed [ps2mpt_pkg::DELTA_W-1:0] dx_c;
	logic signed [ps2mpt_pkg::DELTA_W-1:0] dy_c;
	logic [ps2mpt_pkg::SIZE_W-1:0]         eff_w_c;
	logic [ps2mpt_pkg::SIZE_W-1:0]         eff_h_c;
	logic [ps2mpt_pkg::POS_W-1:0]          next_x_c;
	logic [ps2mpt_pkg::POS_W-1:0]          next_y_c;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= ps2mpt_pkg::WIDTH_RESET;
			height_q <= ps2mpt_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				ps2mpt_pkg::REG_SCREEN_WIDTH:  width_q  <= cfg_wdata;
				ps2mpt_pkg::REG_SCREEN_HEIGHT: height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// The input register moves on unless its Y byte would overwrite a waiting word.
	assign s1_ends_pkt = valid_s1 && (phase_q == PH_Y);
	assign s1_fire     = valid_s1 && !(s1_ends_pkt && out_valid_q && !pkt.ready);
	assign s1_done     = !valid_s1 || s1_fire;
	assign rx.ready    = s1_done;

	// Header test, deltas and clamped cursor for the captured byte.
	assign hdr_ok   = (byte_s1 & ps2mpt_pkg::HDR_MASK) == ps2mpt_pkg::HDR_MATCH;
	assign dx_c     = ps2mpt_pkg::sext_delta(xbyte_q, header_q[ps2mpt_pkg::HDR_XSIGN]);
	assign dy_c     = -ps2mpt_pkg::sext_delta(byte_s1, header_q[ps2mpt_pkg::HDR_YSIGN]);
	assign eff_w_c  = ps2mpt_pkg::eff_size(width_q);
	assign eff_h_c  = ps2mpt_pkg::eff_size(height_q);
	assign next_x_c = ps2mpt_pkg::move_clamp(pos_x_q, dx_c, eff_w_c);
	assign next_y_c = ps2mpt_pkg::move_clamp(pos_y_q, dy_c, eff_h_c);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_done) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_done && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	// Packet phase and stored bytes and position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_ACK;
			header_q <= '0;
			xbyte_q  <= '0;
			pos_x_q  <= '0;
			pos_y_q  <= '0;
		end else if (s1_fire) begin
			case (phase_q)
				PH_ACK: begin
					phase_q <= PH_HDR;
				end
				PH_HDR: begin
					if (hdr_ok) begin
						header_q <= byte_s1;
						phase_q  <= PH_X;
					end
				end
				PH_X: begin
					xbyte_q <= byte_s1;
					phase_q <= PH_Y;
				end
				PH_Y: begin
					pos_x_q <= next_x_c;
					pos_y_q <= next_y_c;
					phase_q <= PH_HDR;
				end
				default: begin
					phase_q <= PH_HDR;
				end
			endcase
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && s1_ends_pkt) begin
			out_valid_q <= 1'b1;
		end else if (pkt.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload; the cursor comes straight from the position.
	always_ff @(posedge clk) begin
		if (s1_fire && s1_ends_pkt) begin
			buttons_q <= header_q[ps2mpt_pkg::BTN_W-1:0];
			delta_x_q <= dx_c;
			delta_y_q <= dy_c;
		end
	end

	assign pkt.valid    = out_valid_q;
	assign pkt.buttons  = buttons_q;
	assign pkt.delta_x  = delta_x_q;
	assign pkt.delta_y  = delta_y_q;
	assign pkt.cursor_x = pos_x_q;
	assign pkt.cursor_y = pos_y_q;

	// A finished packet always lands in the result register.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && s1_ends_pkt) |=> out_valid_q)
		else $error("completed packet not registered");

	// The cursor lands inside the screen in force when the packet completed.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && s1_ends_pkt) |=>
		((13'(pos_x_q) < $past(eff_w_c)) && (13'(pos_y_q) < $past(eff_h_c))))
		else $error("cursor outside screen");

	// Once the acknowledge has gone, the tracker never waits for it again.
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_ACK) |=> (phase_q != PH_ACK))
		else $error("phase returned to acknowledge");

	// A stored header always passes the header test.
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_X || phase_q == PH_Y) |->
		((header_q & ps2mpt_pkg::HDR_MASK) == ps2mpt_pkg::HDR_MATCH))
		else $error("bad header stored");

endmodule
